FILE: hdl/wmec_pkg.sv
// Shared constants, types and error-probability table builder for the fragment cost block.
`timescale 1ns / 1ps

package wmec_pkg;

    localparam int ROM_DEPTH    = 94;
    localparam int PHRED_OFFSET = 33;
    localparam int QC_W         = 7;
    localparam int IDX_W        = 7;
    localparam int ACC_W        = 36;
    localparam int TOTAL_W      = 48;
    localparam int WORK_BITS    = 48;
    localparam int ROM_W        = 32;

    localparam logic [63:0] WORK_ONE   = 64'd1 << WORK_BITS;
    localparam logic [63:0] WORK_TENTH = (64'd1 << WORK_BITS) / 64'd10;

    typedef logic [ROM_DEPTH-1:0][ROM_W-1:0] rom_t;
    typedef logic [IDX_W-1:0] idx_t;

    typedef struct packed {
        logic frag_last;
        logic block_last;
    } site_flags_t;

    function automatic logic [63:0] qmul(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] prod;
        prod = {64'd0, a} * {64'd0, b};
        return prod[111:48];
    endfunction

    function automatic logic [63:0] pow_ten(input logic [63:0] x);
        logic [63:0] y;
        y = x;
        for (int i = 1; i < 10; i++) begin
            y = qmul(y, x);
        end
        return y;
    endfunction

    function automatic rom_t build_rom(input int frac_bits);
        rom_t        rom;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] mid;
        logic [63:0] r;
        logic [63:0] v;
        logic [63:0] e;
        logic [63:0] pmax;
        int          sh;
        rom  = '0;
        lo   = 64'd0;
        hi   = WORK_ONE;
        sh   = WORK_BITS - frac_bits;
        pmax = (64'd1 << frac_bits) - 64'd1;
        while (lo < hi) begin
            mid = lo + ((hi - lo + 64'd1) >> 1);
            if (pow_ten(mid) <= WORK_TENTH) begin
                lo = mid;
            end else begin
                hi = mid - 64'd1;
            end
        end
        r = lo;
        v = WORK_ONE;
        for (int q = 0; q < ROM_DEPTH; q++) begin
            e = (v + (64'd1 << (sh - 1))) >> sh;
            rom[q] = ROM_W'((e > pmax) ? pmax : e);
            v = qmul(v, r);
        end
        return rom;
    endfunction

endpackage

FILE: hdl/wmec_err_lookup.sv
// Quality character clamp and error-probability table lookup with complement.
`timescale 1ns / 1ps

module wmec_err_lookup #(
    parameter int FRAC_BITS = 24
) (
    input  logic [wmec_pkg::QC_W-1:0] quality_char,
    output logic [FRAC_BITS-1:0]      err_prob,
    output logic [FRAC_BITS:0]        err_comp
);
    import wmec_pkg::*;

    localparam rom_t ERR_ROM = build_rom(FRAC_BITS);

    idx_t rom_idx;

    always_comb begin
        if (quality_char < QC_W'(PHRED_OFFSET)) begin
            rom_idx = '0;
        end else if (quality_char > QC_W'(PHRED_OFFSET + ROM_DEPTH - 1)) begin
            rom_idx = IDX_W'(ROM_DEPTH - 1);
        end else begin
            rom_idx = IDX_W'(quality_char - QC_W'(PHRED_OFFSET));
        end
    end

    assign err_prob = ERR_ROM[rom_idx][FRAC_BITS-1:0];
    assign err_comp = {1'b1, {FRAC_BITS{1'b0}}} - {1'b0, err_prob};

endmodule

FILE: hdl/weighted_mec_fragment_cost.sv
// Top level: weighted fragment cost accumulation against haplotype and complement.
// A fragment's last site is registered, then its result is registered for output.
// Throughput: one site per cycle; the site register advances while the result waits.
// A stalled result blocks only a following fragment-last site in the site register.
// Reset (aresetn low, synchronous) empties both stages and clears accumulators and total.
`timescale 1ns / 1ps

module weighted_mec_fragment_cost #(
    parameter int FRAC_BITS = 24
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         s_hap_allele,
    input  logic                         s_read_allele,
    input  logic [wmec_pkg::QC_W-1:0]    s_quality_char,
    input  logic                         s_frag_last,
    input  logic                         s_block_last,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [wmec_pkg::ACC_W-1:0]   m_cost_vs_hap,
    output logic [wmec_pkg::ACC_W-1:0]   m_cost_vs_complement,
    output logic [wmec_pkg::TOTAL_W-1:0] m_block_cost,
    output logic                         m_block_done
);
    import wmec_pkg::*;

    logic [FRAC_BITS-1:0] err_prob;
    logic [FRAC_BITS:0]   err_comp;

    logic                 st_valid_reg;
    site_flags_t          flags_reg;
    logic [FRAC_BITS:0]   add_hap_reg;
    logic [FRAC_BITS:0]   add_comp_reg;

    logic [ACC_W-1:0]     acc_hap_reg;
    logic [ACC_W-1:0]     acc_comp_reg;
    logic [TOTAL_W-1:0]   total_reg;
    logic [ACC_W-1:0]     acc_hap_next;
    logic [ACC_W-1:0]     acc_comp_next;
    logic [TOTAL_W-1:0]   total_next;

    logic                 m_valid_reg;
    logic [ACC_W-1:0]     cost_hap_reg;
    logic [ACC_W-1:0]     cost_comp_reg;
    logic [TOTAL_W-1:0]   block_cost_reg;
    logic                 block_done_reg;

    logic                 s_accept;
    logic                 advance;
    logic                 in_match;
    logic [ACC_W:0]       sum_hap;
    logic [ACC_W:0]       sum_comp;
    logic [ACC_W-1:0]     sat_hap;
    logic [ACC_W-1:0]     sat_comp;
    logic [ACC_W-1:0]     frag_min;
    logic [TOTAL_W:0]     sum_total;
    logic [TOTAL_W-1:0]   sat_total;

    wmec_err_lookup #(
        .FRAC_BITS (FRAC_BITS)
    ) u_err_lookup (
        .quality_char (s_quality_char),
        .err_prob     (err_prob),
        .err_comp     (err_comp)
    );

    assign advance  = st_valid_reg && (!flags_reg.frag_last || !m_valid_reg || m_ready);
    assign s_ready  = !st_valid_reg || advance;
    assign s_accept = s_valid && s_ready;
    assign in_match = (s_hap_allele == s_read_allele);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_valid_reg <= 1'b0;
        end else if (s_ready) begin
            st_valid_reg <= s_valid;
        end
        if (s_accept) begin
            flags_reg.frag_last  <= s_frag_last;
            flags_reg.block_last <= s_block_last;
            add_hap_reg          <= in_match ? {1'b0, err_prob} : err_comp;
            add_comp_reg         <= in_match ? err_comp : {1'b0, err_prob};
        end
    end

    always_comb begin
        sum_hap   = {1'b0, acc_hap_reg} + (ACC_W+1)'(add_hap_reg);
        sum_comp  = {1'b0, acc_comp_reg} + (ACC_W+1)'(add_comp_reg);
        sat_hap   = sum_hap[ACC_W] ? {ACC_W{1'b1}} : sum_hap[ACC_W-1:0];
        sat_comp  = sum_comp[ACC_W] ? {ACC_W{1'b1}} : sum_comp[ACC_W-1:0];
        frag_min  = (sat_hap < sat_comp) ? sat_hap : sat_comp;
        sum_total = {1'b0, total_reg} + (TOTAL_W+1)'(frag_min);
        sat_total = sum_total[TOTAL_W] ? {TOTAL_W{1'b1}} : sum_total[TOTAL_W-1:0];

        acc_hap_next  = acc_hap_reg;
        acc_comp_next = acc_comp_reg;
        total_next    = total_reg;
        if (advance) begin
            if (flags_reg.frag_last) begin
                acc_hap_next  = '0;
                acc_comp_next = '0;
                total_next    = flags_reg.block_last ? '0 : sat_total;
            end else begin
                acc_hap_next  = sat_hap;
                acc_comp_next = sat_comp;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_hap_reg  <= '0;
            acc_comp_reg <= '0;
            total_reg    <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            acc_hap_reg  <= acc_hap_next;
            acc_comp_reg <= acc_comp_next;
            total_reg    <= total_next;
            if (advance && flags_reg.frag_last) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
        if (advance && flags_reg.frag_last) begin
            cost_hap_reg   <= sat_hap;
            cost_comp_reg  <= sat_comp;
            block_cost_reg <= sat_total;
            block_done_reg <= flags_reg.block_last;
        end
    end

    assign m_valid              = m_valid_reg;
    assign m_cost_vs_hap        = cost_hap_reg;
    assign m_cost_vs_complement = cost_comp_reg;
    assign m_block_cost         = block_cost_reg;
    assign m_block_done         = block_done_reg;

endmodule

FILE: hdl/wmec_port_checker.sv
// Port-level checks for the fragment cost block and their binding to the top level.
`timescale 1ns / 1ps

module wmec_port_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_valid,
    input logic                         s_ready,
    input logic                         m_valid,
    input logic                         m_ready,
    input logic [wmec_pkg::ACC_W-1:0]   m_cost_vs_hap,
    input logic [wmec_pkg::ACC_W-1:0]   m_cost_vs_complement,
    input logic [wmec_pkg::TOTAL_W-1:0] m_block_cost,
    input logic                         m_block_done
);
    import wmec_pkg::*;

    logic             block_start_reg;
    logic [ACC_W-1:0] cost_min;

    assign cost_min = (m_cost_vs_hap < m_cost_vs_complement) ?
                      m_cost_vs_hap : m_cost_vs_complement;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            block_start_reg <= 1'b1;
        end else if (m_valid && m_ready) begin
            block_start_reg <= m_block_done;
        end
    end

    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_block_cost) && $stable(m_block_done))
        else $error("result changed while stalled");

    a_total_covers_min: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_block_cost >= TOTAL_W'(cost_min))
        else $error("block total below fragment minimum");

    a_block_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && block_start_reg |-> m_block_cost == TOTAL_W'(cost_min))
        else $error("block total not restarted");

    a_result_after_request: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(s_valid && s_ready, 2))
        else $error("result without matching request");

endmodule

bind weighted_mec_fragment_cost wmec_port_checker u_wmec_port_checker (
    .aclk                 (aclk),
    .aresetn              (aresetn),
    .s_valid              (s_valid),
    .s_ready              (s_ready),
    .m_valid              (m_valid),
    .m_ready              (m_ready),
    .m_cost_vs_hap        (m_cost_vs_hap),
    .m_cost_vs_complement (m_cost_vs_complement),
    .m_block_cost         (m_block_cost),
    .m_block_done         (m_block_done)
);
